>>> rtl/bua_pkg.sv
// ----------------------------------------------------------------------------
// bua_pkg
// Shared types and codes for the budget usage accounting table.
// ----------------------------------------------------------------------------
package bua_pkg;

  localparam int OP_W  = 3;
  localparam int IDX_W = 8;
  localparam int AMT_W = 48;
  localparam int CNT_W = 32;
  localparam int ST_W  = 2;
  localparam int ROW_W = 32;   // occupancy bits per bitmap row

  // request opcodes
  localparam logic [OP_W-1:0] OP_CREATE    = 3'd0;
  localparam logic [OP_W-1:0] OP_DESTROY   = 3'd1;
  localparam logic [OP_W-1:0] OP_ALLOC     = 3'd2;
  localparam logic [OP_W-1:0] OP_DEALLOC   = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_USAGE = 3'd4;
  localparam logic [OP_W-1:0] OP_READ      = 3'd5;

  // result status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_LIMIT     = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] entry_index;
    logic [AMT_W-1:0] amount;
    logic [AMT_W-1:0] new_limit;
  } bua_req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] result_index;
    logic [AMT_W-1:0] usage_now;
    logic [AMT_W-1:0] usage_peak;
    logic [CNT_W-1:0] live_allocations;
    logic [AMT_W-1:0] limit_out;
    logic             entry_valid;
  } bua_rsp_t;

endpackage

>>> rtl/bua_chan_if.sv
// ----------------------------------------------------------------------------
// bua_chan_if
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface bua_chan_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

>>> rtl/budget_usage_accounting_table_top.sv
// ----------------------------------------------------------------------------
// budget_usage_accounting_table_top
// Table of budget entries with create/destroy/allocate/deallocate/set/read.
// ----------------------------------------------------------------------------
// One request at a time is taken from in_chan and answered by exactly one
// result transaction on out_chan. Destroy, allocate, deallocate, set usage
// and read each have a read step, which reads the entry and its occupancy
// row from synchronous memory, and an update step, which updates, writes
// back and loads the result register. Create scans 1 to ceil(ENTRIES/32)
// 32-bit occupancy rows, one row per cycle from the bitmap memory, until
// the lowest free entry is found. The result register
// lets a new request be accepted while the previous result still waits; the
// update stage holds (without writing) until the register is free. Per-row
// valid flops stand in for the cleared occupancy at reset, so no clearing
// pass is needed and the block takes requests right after reset. Entry
// fields are stored at SIZE_BITS width and reported truncated or
// zero-extended to 48 bits. entry_index is 8 bits, so with ENTRIES above
// 256 the upper entries can be created but not addressed.
// ----------------------------------------------------------------------------
module budget_usage_accounting_table_top #(
  parameter int ENTRIES   = 256,
  parameter int SIZE_BITS = 48
) (
  input logic         clk,
  input logic         rst_n,
  bua_chan_if.sink    in_chan,
  bua_chan_if.source  out_chan
);
  import bua_pkg::*;

  localparam int ROWS = (ENTRIES + ROW_W - 1) / ROW_W;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;   // bitmap row address
  localparam int BW   = $clog2(ROW_W);                   // bit within a row
  localparam int EIW  = RAW + BW;                        // row:bit entry number
  localparam int IDXW = $clog2(ENTRIES);                 // entry memory address
  localparam int XW   = ((EIW > IDX_W) ? EIW : IDX_W) + 1;
  localparam int SW   = SIZE_BITS;

  localparam logic [XW-1:0]  ENTRIES_X = XW'(ENTRIES);
  localparam logic [RAW-1:0] LAST_ROW  = RAW'(ROWS - 1);
  localparam logic [SW-1:0]  SIZE_MAX  = '1;

  typedef struct packed {
    logic [SW-1:0]    limit;
    logic [SW-1:0]    usage;
    logic [SW-1:0]    peak;
    logic [CNT_W-1:0] count;
  } entry_t;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EXEC} state_t;

  // --- registers -----------------------------------------------------------
  state_t           state_r, state_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [SW-1:0]    amt_r, amt_nxt;
  logic [SW-1:0]    lim_r, lim_nxt;
  logic [RAW-1:0]   scan_row_r, scan_row_nxt;
  logic [ROWS-1:0]  row_vld_r, row_vld_nxt;
  logic             out_valid_r, out_valid_nxt;
  bua_rsp_t         out_data_r, out_data_nxt;

  // --- memories ------------------------------------------------------------
  logic [ROW_W-1:0] map_mem [ROWS];
  logic [ROW_W-1:0] map_rd_r;
  entry_t           ent_mem [ENTRIES];
  entry_t           ent_rd_r;

  logic             map_re, map_we;
  logic [RAW-1:0]   map_raddr, map_waddr;
  logic [ROW_W-1:0] map_wdata;
  logic             ent_re, ent_we;
  logic [IDXW-1:0]  ent_raddr, ent_waddr;
  entry_t           ent_wdata;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (map_re) map_rd_r <= map_mem[map_raddr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    if (ent_re) ent_rd_r <= ent_mem[ent_raddr];
  end

  // --- request decode ------------------------------------------------------
  logic [XW-1:0]    in_x, idx_x;
  logic [RAW-1:0]   row_sel;
  logic [BW-1:0]    bit_sel;
  logic [ROW_W-1:0] row_bits;      // occupancy of the addressed row
  logic [ROW_W-1:0] bit_mask;
  logic             in_range, hit;
  logic             out_free;

  assign in_x     = XW'(in_chan.data.entry_index);
  assign idx_x    = XW'(idx_r);
  assign row_sel  = idx_x[EIW-1:BW];
  assign bit_sel  = idx_x[BW-1:0];
  assign in_range = idx_x < ENTRIES_X;
  assign row_bits = row_vld_r[row_sel] ? map_rd_r : '0;
  assign bit_mask = ROW_W'(1) << bit_sel;
  assign hit      = in_range && row_bits[bit_sel] && (op_r <= OP_READ);
  assign out_free = !out_valid_r || out_chan.ready;

  // --- free-entry scan of one bitmap row -------------------------------------
  logic [ROW_W-1:0] scan_raw, scan_pad, scan_free;
  logic [BW-1:0]    free_bit;
  logic             found, last_row;
  logic [EIW-1:0]   new_ent;

  assign scan_raw = row_vld_r[scan_row_r] ? map_rd_r : '0;

  always_comb begin
    for (int b = 0; b < ROW_W; b++) begin
      scan_pad[b] = XW'({scan_row_r, BW'(b)}) >= ENTRIES_X;
    end
  end

  assign scan_free = ~(scan_raw | scan_pad);
  assign found     = |scan_free;
  assign last_row  = scan_row_r == LAST_ROW;
  assign new_ent   = {scan_row_r, free_bit};

  always_comb begin
    free_bit = '0;
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (scan_free[b]) free_bit = BW'(b);
    end
  end

  // --- entry datapath --------------------------------------------------------
  logic [SW:0]   sum, diff;
  logic          alloc_refuse, set_over;
  logic [SW-1:0] alloc_u, dealloc_u, alloc_peak, set_peak;

  assign sum          = {1'b0, ent_rd_r.usage} + {1'b0, amt_r};
  assign diff         = {1'b0, ent_rd_r.usage} - {1'b0, amt_r};
  // u + a > l covers both "usage already over" and "amount over headroom"
  assign alloc_refuse = (ent_rd_r.limit != '0) && (sum > {1'b0, ent_rd_r.limit});
  assign alloc_u      = sum[SW] ? SIZE_MAX : sum[SW-1:0];
  assign dealloc_u    = diff[SW] ? '0 : diff[SW-1:0];
  assign alloc_peak   = (alloc_u > ent_rd_r.peak) ? alloc_u : ent_rd_r.peak;
  assign set_peak     = (amt_r > ent_rd_r.peak) ? amt_r : ent_rd_r.peak;
  assign set_over     = (ent_rd_r.limit != '0) && (amt_r > ent_rd_r.limit);

  function automatic bua_rsp_t make_rsp(input logic [ST_W-1:0]  st,
                                        input logic [IDX_W-1:0] ix,
                                        input entry_t           e,
                                        input logic             v);
    bua_rsp_t r;
    r.status           = st;
    r.result_index     = ix;
    r.usage_now        = v ? AMT_W'(e.usage) : '0;
    r.usage_peak       = v ? AMT_W'(e.peak)  : '0;
    r.live_allocations = v ? e.count         : '0;
    r.limit_out        = v ? AMT_W'(e.limit) : '0;
    r.entry_valid      = v;
    return r;
  endfunction

  // --- control -------------------------------------------------------------
  entry_t        nw;
  logic [ST_W-1:0] st;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    amt_nxt       = amt_r;
    lim_nxt       = lim_r;
    scan_row_nxt  = scan_row_r;
    row_vld_nxt   = row_vld_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_data_nxt  = out_data_r;

    map_re    = 1'b0;
    map_raddr = in_x[EIW-1:BW];
    map_we    = 1'b0;
    map_waddr = row_sel;
    map_wdata = row_bits;
    ent_re    = 1'b0;
    ent_raddr = in_x[IDXW-1:0];
    ent_we    = 1'b0;
    ent_waddr = idx_x[IDXW-1:0];
    ent_wdata = ent_rd_r;
    nw        = ent_rd_r;
    st        = ST_OK;

    case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          op_nxt  = in_chan.data.op;
          idx_nxt = in_chan.data.entry_index;
          amt_nxt = SW'(in_chan.data.amount);
          lim_nxt = SW'(in_chan.data.new_limit);
          map_re  = 1'b1;
          if (in_chan.data.op == OP_CREATE) begin
            scan_row_nxt = '0;
            map_raddr    = '0;
            state_nxt    = S_SCAN;
          end else begin
            ent_re    = 1'b1;
            state_nxt = S_EXEC;
          end
        end
      end

      S_SCAN: begin
        if (found || last_row) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (found) begin
              nw.limit  = lim_r;
              nw.usage  = '0;
              nw.peak   = '0;
              nw.count  = '0;
              ent_we    = 1'b1;
              ent_waddr = new_ent[IDXW-1:0];
              ent_wdata = nw;
              map_we    = 1'b1;
              map_waddr = scan_row_r;
              map_wdata = scan_raw | (ROW_W'(1) << free_bit);
              row_vld_nxt[scan_row_r] = 1'b1;
              out_data_nxt = make_rsp(ST_OK, IDX_W'(new_ent), nw, 1'b1);
            end else begin
              out_data_nxt = make_rsp(ST_FULL, '0, nw, 1'b0);
            end
          end
        end else begin
          scan_row_nxt = scan_row_r + RAW'(1);
          map_raddr    = scan_row_r + RAW'(1);
          map_re       = 1'b1;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (!hit) begin
            out_data_nxt = make_rsp(ST_NOT_FOUND, idx_r, nw, 1'b0);
          end else begin
            case (op_r)
              OP_DESTROY: begin
                nw.usage  = '0;
                nw.peak   = '0;
                nw.count  = '0;
                ent_we    = 1'b1;
                map_we    = 1'b1;
                map_wdata = row_bits & ~bit_mask;
              end
              OP_ALLOC: begin
                if (alloc_refuse) begin
                  st = ST_LIMIT;
                end else begin
                  nw.usage = alloc_u;
                  nw.peak  = alloc_peak;
                  nw.count = ent_rd_r.count + CNT_W'(1);
                  ent_we   = 1'b1;
                end
              end
              OP_DEALLOC: begin
                nw.usage = dealloc_u;
                nw.count = (ent_rd_r.count != '0) ? ent_rd_r.count - CNT_W'(1) : '0;
                ent_we   = 1'b1;
              end
              OP_SET_USAGE: begin
                nw.usage = amt_r;
                nw.peak  = set_peak;
                st       = set_over ? ST_LIMIT : ST_OK;
                ent_we   = 1'b1;
              end
              default: begin
                // read: report only
              end
            endcase
            ent_wdata    = nw;
            out_data_nxt = make_rsp(st, idx_r, nw, op_r != OP_DESTROY);
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
      scan_row_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= out_valid_nxt;
      scan_row_r  <= scan_row_nxt;
    end
    op_r       <= op_nxt;
    idx_r      <= idx_nxt;
    amt_r      <= amt_nxt;
    lim_r      <= lim_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

`ifndef SYNTH
  // one request in flight: nothing is taken in the cycle after a transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("request accepted while previous one still in work");

  // failed lookups and a full table report an empty entry
  a_miss_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.data.status == ST_NOT_FOUND ||
                        out_chan.data.status == ST_FULL))
    |-> (!out_chan.data.entry_valid && out_chan.data.usage_now == '0 &&
         out_chan.data.live_allocations == '0))
    else $error("miss or full result carries entry data");

  // peak never falls below current usage
  a_peak_ge_usage: assert property (@(posedge clk) disable iff (!rst_n)
    ((SW <= AMT_W) && out_chan.valid && out_chan.data.entry_valid)
    |-> (out_chan.data.usage_peak >= out_chan.data.usage_now))
    else $error("peak below usage");

  // free-entry scan stays inside the bitmap
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_row_r <= LAST_ROW))
    else $error("scan row past end of bitmap");
`endif

endmodule
